>>> hdl/xte_pkg.sv
// ----------------------------------------------------------------------------
// xte_pkg
// Shared types and constants of the XML tag extractor: mode codes, result
// kinds, error codes, the characters that steer the scan, and result records.
// ----------------------------------------------------------------------------
package xte_pkg;

  // scan modes
  localparam logic [2:0] MODE_TEXT    = 3'd0;
  localparam logic [2:0] MODE_LOOK    = 3'd1;
  localparam logic [2:0] MODE_TAG     = 3'd2;
  localparam logic [2:0] MODE_COMMENT = 3'd3;
  localparam logic [2:0] MODE_ENTITY  = 3'd4;

  // result kinds
  localparam logic [1:0] KIND_BYTE    = 2'd0;
  localparam logic [1:0] KIND_END_TAG = 2'd1;
  localparam logic [1:0] KIND_ERROR   = 2'd2;

  // error codes
  localparam logic [7:0] ERR_UNEXPECTED_END = 8'd0;
  localparam logic [7:0] ERR_BAD_ENTITY     = 8'd1;

  // characters of interest
  localparam logic [7:0] CH_LT   = 8'h3C; // '<'
  localparam logic [7:0] CH_GT   = 8'h3E; // '>'
  localparam logic [7:0] CH_AMP  = 8'h26; // '&'
  localparam logic [7:0] CH_SEMI = 8'h3B; // ';'
  localparam logic [7:0] CH_BANG = 8'h21; // '!'
  localparam logic [7:0] CH_DASH = 8'h2D; // '-'
  localparam logic [7:0] CH_HASH = 8'h23; // '#'

  // most results one item can cause
  localparam int MAX_RESULTS = 3;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] value;
  } entry_t;

  typedef struct packed {
    logic [2:0] mode;
    logic [1:0] matched;
    logic [1:0] dash_run;
  } scan_state_t;

  typedef struct packed {
    scan_state_t                   state_next;
    logic [1:0]                    count;
    entry_t [MAX_RESULTS-1:0]      ent;
  } decode_t;

endpackage

>>> hdl/xml_tag_extractor_core.sv
// ----------------------------------------------------------------------------
// xml_tag_extractor_core
// Scans XML text one byte per item and passes on the bytes inside tags,
// end-of-tag marks and errors, skipping comments and checking entities.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall): one item per accepted edge, carrying
//   text_byte, or end_of_input set to close the document.
//   Output channel (out_valid / out_stall): results of kind, value and last;
//   last marks the final result caused by one input item.
//   An accepted item passes the input register, then the result register,
//   before its first result can be taken. Throughput: one item per cycle
//   while each item causes at most one result and the receiver does not
//   stall. An item that causes several results holds the result register
//   until all are taken; a failed lookahead flush or an error after "<!" or
//   "<!-" causes up to three, and items causing no result never occupy it.
//   Reset clears the scan state to plain text and empties both registers.
//   When the receiver stalls, the shown result holds, the result register
//   stays full and in_stall rises once the input register is also occupied.
// ----------------------------------------------------------------------------
module xml_tag_extractor_core (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] text_byte,
  input  logic       end_of_input,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [1:0] kind,
  output logic [7:0] value,
  output logic       last
);

  localparam int MaxResults = xte_pkg::MAX_RESULTS;
  localparam int CntW       = $clog2(MaxResults + 1);

  logic                                  in_full;
  logic [7:0]                            in_byte;
  logic                                  in_end;
  xte_pkg::scan_state_t                  state;
  xte_pkg::decode_t                      dec;
  xte_pkg::entry_t [MaxResults-1:0]      ent;
  logic [CntW-1:0]                       rem;
  logic                                  buf_free;
  logic                                  buf_load;
  logic                                  out_take;

  // handshake control
  assign out_valid = (rem != '0);
  assign out_take  = out_valid && !out_stall;
  assign buf_free  = (rem == '0) || (rem == CntW'(1) && !out_stall);
  assign buf_load  = in_full && buf_free;
  assign in_stall  = in_full && !buf_load;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (!in_stall) begin
      in_full <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_byte <= text_byte;
      in_end  <= end_of_input;
    end
  end

  // scan step
  xte_decode u_decode (
    .state        (state),
    .text_byte    (in_byte),
    .end_of_input (in_end),
    .dec          (dec)
  );

  // scan state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '{mode: xte_pkg::MODE_TEXT, matched: 2'd0, dash_run: 2'd0};
    end else if (buf_load) begin
      state <= dec.state_next;
    end
  end

  // result register, drained one entry per cycle while the receiver does not stall
  always_ff @(posedge clk) begin
    if (rst) begin
      rem <= '0;
    end else if (buf_load) begin
      rem <= CntW'(dec.count);
    end else if (out_take) begin
      rem <= rem - CntW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (buf_load) begin
      ent <= dec.ent;
    end else if (out_take) begin
      for (int i = 0; i < MaxResults - 1; i++) begin
        ent[i] <= ent[i+1];
      end
    end
  end

  // output fields
  assign kind  = ent[0].kind;
  assign value = ent[0].value;
  assign last  = (rem == CntW'(1));

`ifndef SYNTH
  // a partial "!--" match exists only during lookahead
  a_match_in_look: assert property (@(posedge clk) disable iff (rst)
    (state.matched != 2'd0) |-> (state.mode == xte_pkg::MODE_LOOK))
    else $error("lookahead count set outside lookahead");

  // a dash run exists only inside a comment
  a_dash_in_comment: assert property (@(posedge clk) disable iff (rst)
    (state.dash_run != 2'd0) |-> (state.mode == xte_pkg::MODE_COMMENT))
    else $error("dash run set outside comment");

  // an error is always the final result of its item
  a_error_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && kind == xte_pkg::KIND_ERROR) |-> last)
    else $error("error result not marked last");

  // a taken final result with nothing waiting leaves the output empty
  a_drain_empty: assert property (@(posedge clk) disable iff (rst)
    (out_take && last && !in_full) |=> !out_valid)
    else $error("output still valid after final result taken");
`endif

endmodule

>>> hdl/xte_decode.sv
// ----------------------------------------------------------------------------
// xte_decode
// Combinational scan step: from the current scan state and one input item,
// works out the next state and the list of results (up to three) it causes.
// ----------------------------------------------------------------------------
module xte_decode (
  input  xte_pkg::scan_state_t state,
  input  logic [7:0]           text_byte,
  input  logic                 end_of_input,
  output xte_pkg::decode_t     dec
);

  // byte allowed inside an entity reference
  function automatic logic entity_ok(input logic [7:0] c);
    entity_ok = (c == xte_pkg::CH_HASH) ||
                (c >= 8'h61 && c <= 8'h7A) ||
                (c >= 8'h41 && c <= 8'h5A) ||
                (c >= 8'h30 && c <= 8'h39);
  endfunction

  logic [1:0]      pre;
  logic            fin_en;
  xte_pkg::entry_t fin;
  logic [7:0]      want;
  xte_pkg::entry_t tag_res;
  logic [2:0]      tag_mode;

  // result of a byte handled as part of a tag
  always_comb begin
    if (text_byte == xte_pkg::CH_GT) begin
      tag_res  = '{kind: xte_pkg::KIND_END_TAG, value: 8'd0};
      tag_mode = xte_pkg::MODE_TEXT;
    end else begin
      tag_res  = '{kind: xte_pkg::KIND_BYTE, value: text_byte};
      tag_mode = xte_pkg::MODE_TAG;
    end
  end

  assign want = (state.matched == 2'd0) ? xte_pkg::CH_BANG : xte_pkg::CH_DASH;

  // next state, flushed prefix length, final result and the result list
  always_comb begin
    dec.state_next = state;
    pre            = 2'd0;
    fin_en         = 1'b0;
    fin            = '0;
    if (end_of_input) begin
      if (state.mode == xte_pkg::MODE_LOOK) begin
        pre    = state.matched;
        fin_en = 1'b1;
        fin    = '{kind: xte_pkg::KIND_ERROR, value: xte_pkg::ERR_UNEXPECTED_END};
      end else if (state.mode == xte_pkg::MODE_TAG ||
                   state.mode == xte_pkg::MODE_COMMENT ||
                   state.mode == xte_pkg::MODE_ENTITY) begin
        fin_en = 1'b1;
        fin    = '{kind: xte_pkg::KIND_ERROR, value: xte_pkg::ERR_UNEXPECTED_END};
      end
      dec.state_next = '{mode: xte_pkg::MODE_TEXT, matched: 2'd0, dash_run: 2'd0};
    end else begin
      unique case (state.mode)
        xte_pkg::MODE_LOOK: begin
          if (state.matched != 2'd3 && text_byte == want) begin
            if (state.matched == 2'd2) begin
              dec.state_next.matched  = 2'd0;
              dec.state_next.dash_run = 2'd0;
              dec.state_next.mode     = xte_pkg::MODE_COMMENT;
            end else begin
              dec.state_next.matched = state.matched + 2'd1;
            end
          end else begin
            // lookahead failed: flush what matched, then treat as tag byte
            pre                    = state.matched;
            dec.state_next.matched = 2'd0;
            fin_en                 = 1'b1;
            fin                    = tag_res;
            dec.state_next.mode    = tag_mode;
          end
        end
        xte_pkg::MODE_TAG: begin
          fin_en              = 1'b1;
          fin                 = tag_res;
          dec.state_next.mode = tag_mode;
        end
        xte_pkg::MODE_COMMENT: begin
          if (text_byte == xte_pkg::CH_GT && state.dash_run == 2'd2) begin
            dec.state_next.mode     = xte_pkg::MODE_TEXT;
            dec.state_next.dash_run = 2'd0;
          end else if (text_byte == xte_pkg::CH_DASH) begin
            if (state.dash_run < 2'd2) begin
              dec.state_next.dash_run = state.dash_run + 2'd1;
            end
          end else begin
            dec.state_next.dash_run = 2'd0;
          end
        end
        xte_pkg::MODE_ENTITY: begin
          if (text_byte == xte_pkg::CH_SEMI) begin
            dec.state_next.mode = xte_pkg::MODE_TEXT;
          end else if (!entity_ok(text_byte)) begin
            fin_en              = 1'b1;
            fin                 = '{kind: xte_pkg::KIND_ERROR,
                                    value: xte_pkg::ERR_BAD_ENTITY};
            dec.state_next.mode = xte_pkg::MODE_TEXT;
          end
        end
        default: begin
          // plain text, and the unused codes behave the same
          dec.state_next.mode = xte_pkg::MODE_TEXT;
          if (text_byte == xte_pkg::CH_LT) begin
            dec.state_next.mode    = xte_pkg::MODE_LOOK;
            dec.state_next.matched = 2'd0;
          end else if (text_byte == xte_pkg::CH_AMP) begin
            dec.state_next.mode = xte_pkg::MODE_ENTITY;
          end
        end
      endcase
    end

    // assemble the result list: flushed '!' and '-', then the final result
    dec.ent = '0;
    if (pre >= 2'd1) begin
      dec.ent[0] = '{kind: xte_pkg::KIND_BYTE, value: xte_pkg::CH_BANG};
    end
    if (pre >= 2'd2) begin
      dec.ent[1] = '{kind: xte_pkg::KIND_BYTE, value: xte_pkg::CH_DASH};
    end
    if (fin_en) begin
      dec.ent[pre] = fin;
    end
    dec.count = pre + {1'b0, fin_en};
  end

endmodule
